@@ hdl/lvg_pkg.sv @@
// ----------------------------------------------------------------------------
// lvg_pkg
// Shared constants, types and codes of the LRU victim group block.
// ----------------------------------------------------------------------------
`default_nettype none

package lvg_pkg;

  localparam int SETS        = 64;
  localparam int WAYS        = 8;
  localparam int TIME_BITS   = 32;
  localparam int SET_AW      = $clog2(SETS);
  localparam int COST_BITS   = 8;
  localparam int CNT_W       = $clog2(WAYS + 1);
  localparam int GROUP_RESET = 4;

  typedef enum logic [1:0] {
    OP_INVALIDATE = 2'd0,
    OP_TOUCH      = 2'd1,
    OP_FILL       = 2'd2,
    OP_VICTIM     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_SELECT
  } state_e;

  typedef logic [WAYS-1:0][TIME_BITS-1:0] row_t;
  typedef logic [WAYS-1:0][CNT_W-1:0]     ranks_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [SET_AW-1:0] addr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ hdl/lvg_stamp_mem.sv @@
// ----------------------------------------------------------------------------
// lvg_stamp_mem
// Timestamp memory, one row of all way stamps per set, with one valid bit per
// row so that a row never written since reset reads as all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lvg_stamp_mem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lvg_pkg::mem_req_t req_i,
  input  wire lvg_pkg::row_t     wr_row_i,
  output lvg_pkg::row_t          rd_row_o
);
  import lvg_pkg::*;

  row_t            mem_q [SETS];
  row_t            rd_row_q;
  logic [SETS-1:0] valid_q;
  logic            rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= wr_row_i;
    end
    if (req_i.rd_en) begin
      rd_row_q <= mem_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rd_row_o = rd_valid_q ? rd_row_q : '0;

endmodule

`default_nettype wire

@@ hdl/lvg_rank.sv @@
// ----------------------------------------------------------------------------
// lvg_rank
// Ranks the ways of one set from oldest to newest into a register, then picks
// the way of lowest shift cost among the oldest group.
// ----------------------------------------------------------------------------
`default_nettype none

module lvg_rank (
  input  wire logic                      clk_i,
  input  wire logic                      rank_en_i,
  input  wire lvg_pkg::row_t             row_i,
  input  wire logic [63:0]               costs_i,
  input  wire logic [lvg_pkg::CNT_W-1:0] group_i,
  output logic [2:0]                     best_way_o,
  output logic [lvg_pkg::COST_BITS-1:0]  best_cost_o
);
  import lvg_pkg::*;

  ranks_t rank_d;
  ranks_t rank_q;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rank_d[w] = '0;
      for (int v = 0; v < WAYS; v++) begin
        if (row_i[v] < row_i[w] || (row_i[v] == row_i[w] && v < w)) begin
          rank_d[w] = rank_d[w] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rank_en_i) begin
      rank_q <= rank_d;
    end
  end

  always_comb begin
    logic [COST_BITS:0] best_cost;
    logic [CNT_W-1:0]   best_rank;
    logic [2:0]         best_way;
    logic [COST_BITS:0] cost;
    best_cost = {1'b1, {COST_BITS{1'b0}}};
    best_rank = '0;
    best_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      cost = {1'b0, costs_i[COST_BITS*w +: COST_BITS]};
      if (rank_q[w] < group_i &&
          (cost < best_cost || (cost == best_cost && rank_q[w] < best_rank))) begin
        best_cost = cost;
        best_rank = rank_q[w];
        best_way  = 3'(w);
      end
    end
    best_way_o  = best_way;
    best_cost_o = best_cost[COST_BITS-1:0];
  end

endmodule

`default_nettype wire

@@ hdl/lru_victim_group_min_shift_top.sv @@
// ----------------------------------------------------------------------------
// lru_victim_group_min_shift_top
// Timestamp LRU replacement with a victim group chosen by shift cost.
//
// An item is taken at a rising edge with start high and busy low. The set row
// is read from the timestamp memory in the next cycle. Invalidate, touch and
// fill then write the row back with the addressed way updated and give no
// result. A victim request ranks the row into a register, selects the way in
// the following cycle and shows the result on victim_way_o and
// victim_shift_o with result_valid_o high for one cycle. A new item may be
// started in that same cycle. The block takes no new item while busy; a
// victim request passes the memory read, the rank register and the select
// stage in turn. The receiver cannot stall; each result is shown once.
// The user must write the group size register through cfg_valid_i and
// cfg_ready_o only while the block is idle; the block itself does not
// enforce this, and ready is always high.
// Reset clears the valid bits of all set rows at once, so every timestamp
// reads as zero and the block is ready in the first cycle after reset;
// the group size returns to 4.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_victim_group_min_shift_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    op_i,
  input  wire logic [5:0]                    set_index_i,
  input  wire logic [2:0]                    way_i,
  input  wire logic [31:0]                   now_time_i,
  input  wire logic [63:0]                   shift_costs_i,
  output logic                               result_valid_o,
  output logic [2:0]                         victim_way_o,
  output logic [lvg_pkg::COST_BITS-1:0]      victim_shift_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [3:0]                    cfg_group_size_i
);
  import lvg_pkg::*;

  state_e                 state_q, state_d;
  op_e                    op_q;
  logic [5:0]             set_q;
  logic [2:0]             way_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [63:0]            costs_q;
  logic [3:0]             group_size_q;
  logic [CNT_W-1:0]       group;
  logic                   set_ok;
  logic                   way_ok;
  logic                   accept;
  logic                   rank_en;
  logic                   sel_load;
  mem_req_t               mem_req;
  row_t                   rd_row;
  row_t                   wr_row;
  logic [2:0]             best_way;
  logic [COST_BITS-1:0]   best_cost;
  logic                   result_valid_q;
  logic [2:0]             victim_way_q;
  logic [COST_BITS-1:0]   victim_shift_q;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign set_ok      = 32'(set_q) < SETS;
  assign way_ok      = 32'(way_q) < WAYS;

  always_comb begin
    if (group_size_q == 4'd0) begin
      group = CNT_W'(1);
    end else if (32'(group_size_q) > WAYS) begin
      group = CNT_W'(WAYS);
    end else begin
      group = CNT_W'(group_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      group_size_q   <= 4'(GROUP_RESET);
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= sel_load;
      if (cfg_valid_i && cfg_ready_o) begin
        group_size_q <= cfg_group_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(op_i);
      set_q   <= set_index_i;
      way_q   <= way_i;
      now_q   <= TIME_BITS'(now_time_i);
      costs_q <= shift_costs_i;
    end
    if (sel_load) begin
      victim_way_q   <= best_way;
      victim_shift_q <= best_cost;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = set_ok ? ST_EVAL : ST_IDLE;
      end
      ST_EVAL: begin
        state_d = (op_q == OP_VICTIM) ? ST_SELECT : ST_IDLE;
      end
      ST_SELECT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    mem_req.rd_en = 1'b0;
    mem_req.wr_en = 1'b0;
    mem_req.addr  = SET_AW'(set_q);
    rank_en       = 1'b0;
    sel_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_READ: begin
        mem_req.rd_en = set_ok;
      end
      ST_EVAL: begin
        mem_req.wr_en = (op_q != OP_VICTIM) && way_ok;
        rank_en       = (op_q == OP_VICTIM);
      end
      ST_SELECT: begin
        sel_load = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_comb begin
    wr_row = rd_row;
    for (int w = 0; w < WAYS; w++) begin
      if (way_q == 3'(w)) begin
        wr_row[w] = (op_q == OP_INVALIDATE) ? '0 : now_q;
      end
    end
  end

  lvg_stamp_mem u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .wr_row_i (wr_row),
    .rd_row_o (rd_row)
  );

  lvg_rank u_rank (
    .clk_i       (clk_i),
    .rank_en_i   (rank_en),
    .row_i       (rd_row),
    .costs_i     (costs_q),
    .group_i     (group),
    .best_way_o  (best_way),
    .best_cost_o (best_cost)
  );

  assign result_valid_o = result_valid_q;
  assign victim_way_o   = victim_way_q;
  assign victim_shift_o = victim_shift_q;

endmodule

`default_nettype wire

@@ hdl/lvg_checker.sv @@
// ----------------------------------------------------------------------------
// lvg_checker
// Port level checks of the LRU victim group block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lvg_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] op_i,
  input wire logic       result_valid_o
);
  import lvg_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block not busy after an accepted item");

  a_victim_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_VICTIM) |-> ##4 result_valid_o)
    else $error("victim request gave no result four cycles later");

  a_no_result_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i != OP_VICTIM) |-> ##4 !result_valid_o)
    else $error("result appeared for an item that gives none");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while the block is busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

bind lru_victim_group_min_shift_top lvg_checker u_lvg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .op_i           (op_i),
  .result_valid_o (result_valid_o)
);

`default_nettype wire
